[hw/rtl/sqi_pkg.sv]
// sqi_pkg: widths, stage payload types and the shared range check
// for the segment / quadrant intersection pipeline. no dependencies.
package sqi_pkg;

	localparam int MAX_LEVEL = 30;
	localparam int LVL_W     = 5;
	localparam int TREE_W    = 3;
	localparam int QC_W      = 30;
	localparam int SC_W      = 31;
	localparam int SIDE_W    = MAX_LEVEL + 1;
	localparam int DW        = SC_W + 1;
	localparam int NW        = DW + 1;
	localparam int PW        = 2 * DW;

	localparam int EDGE_BOTTOM = 0;
	localparam int EDGE_TOP    = 1;
	localparam int EDGE_LEFT   = 2;
	localparam int EDGE_RIGHT  = 3;
	localparam int NUM_EDGES   = 4;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic                  ok;
		logic [LVL_W-1:0]      sh;
		logic signed [DW-1:0]  ux;
		logic signed [DW-1:0]  uy;
		logic signed [DW-1:0]  wx;
		logic signed [DW-1:0]  wy;
	} prep_t;

	typedef struct packed {
		logic                  ok;
		logic                  enclosed;
		logic [NUM_EDGES-1:0]  nt_ok;
		logic signed [PW-1:0]  p1;
		logic signed [PW-1:0]  p2;
		logic signed [PW-1:0]  uxs;
		logic signed [PW-1:0]  uys;
	} prod_t;

	// true when a / d lies in [0, 1] with d nonzero
	function automatic logic in_unit(input logic signed [PW-1:0] a,
	                                 input logic signed [PW-1:0] d);
		logic r;
		if (d > 0) begin
			r = (a >= 0) && (a <= d);
		end else if (d < 0) begin
			r = (a <= 0) && (a >= d);
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

endpackage

[hw/rtl/sqi_prep.sv]
// sqi_prep: first stage, tree and level gating, side shift and the
// endpoint differences. depends on sqi_pkg.
module sqi_prep (
	input  logic                        clk,
	input  sqi_pkg::stage_en_t          en,
	input  logic [sqi_pkg::LVL_W-1:0]   target_level,
	input  logic [sqi_pkg::TREE_W-1:0]  quad_tree,
	input  logic [sqi_pkg::QC_W-1:0]    quad_x,
	input  logic [sqi_pkg::QC_W-1:0]    quad_y,
	input  logic [sqi_pkg::LVL_W-1:0]   quad_level,
	input  logic [sqi_pkg::TREE_W-1:0]  seg_tree,
	input  logic [sqi_pkg::SC_W-1:0]    seg_x1,
	input  logic [sqi_pkg::SC_W-1:0]    seg_y1,
	input  logic [sqi_pkg::SC_W-1:0]    seg_x2,
	input  logic [sqi_pkg::SC_W-1:0]    seg_y2,
	output sqi_pkg::prep_t              prep_s1
);
	import sqi_pkg::*;

	logic [LVL_W-1:0] eff;
	prep_t            prep_d;

	always_comb begin
		eff = (quad_level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : quad_level;
		prep_d.ok = (quad_tree == seg_tree) && (quad_level < target_level);
		prep_d.sh = LVL_W'(MAX_LEVEL) - eff;
		prep_d.ux = $signed({1'b0, seg_x2}) - $signed({1'b0, seg_x1});
		prep_d.uy = $signed({1'b0, seg_y2}) - $signed({1'b0, seg_y1});
		prep_d.wx = $signed({1'b0, seg_x1}) - $signed({{(DW-QC_W){1'b0}}, quad_x});
		prep_d.wy = $signed({1'b0, seg_y1}) - $signed({{(DW-QC_W){1'b0}}, quad_y});
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prep_s1 <= prep_d;
		end
	end

endmodule

[hw/rtl/sqi_prod.sv]
// sqi_prod: second stage, the two cross products, the side-scaled
// direction terms and the narrow edge parameter tests. depends on sqi_pkg.
module sqi_prod (
	input  logic                clk,
	input  sqi_pkg::stage_en_t  en,
	input  sqi_pkg::prep_t      prep_s1,
	output sqi_pkg::prod_t      prod_s2
);
	import sqi_pkg::*;

	logic [SIDE_W-1:0]     side;
	logic signed [NW-1:0]  sd, ux_n, uy_n, wx_n, wy_n, wxr, wyt;
	logic signed [PW-1:0]  ux_w, uy_w, wx_w, wy_w;
	prod_t                 prod_d;

	function automatic logic signed [PW-1:0] ext_n(input logic signed [NW-1:0] v);
		return $signed({{(PW-NW){v[NW-1]}}, v});
	endfunction

	always_comb begin
		side = SIDE_W'(1) << prep_s1.sh;
		sd   = $signed({{(NW-SIDE_W){1'b0}}, side});
		ux_n = $signed({prep_s1.ux[DW-1], prep_s1.ux});
		uy_n = $signed({prep_s1.uy[DW-1], prep_s1.uy});
		wx_n = $signed({prep_s1.wx[DW-1], prep_s1.wx});
		wy_n = $signed({prep_s1.wy[DW-1], prep_s1.wy});
		wxr  = wx_n - sd;
		wyt  = wy_n - sd;
		ux_w = $signed({{(PW-DW){prep_s1.ux[DW-1]}}, prep_s1.ux});
		uy_w = $signed({{(PW-DW){prep_s1.uy[DW-1]}}, prep_s1.uy});
		wx_w = $signed({{(PW-DW){prep_s1.wx[DW-1]}}, prep_s1.wx});
		wy_w = $signed({{(PW-DW){prep_s1.wy[DW-1]}}, prep_s1.wy});

		prod_d.ok       = prep_s1.ok;
		prod_d.enclosed = (wx_n >= 0) && (wxr <= 0) && (wy_n >= 0) && (wyt <= 0);
		// edge parameter, common side factor removed
		prod_d.nt_ok[EDGE_BOTTOM] = in_unit(ext_n(wy_n), ext_n(-uy_n));
		prod_d.nt_ok[EDGE_TOP]    = in_unit(ext_n(wyt), ext_n(-uy_n));
		prod_d.nt_ok[EDGE_LEFT]   = in_unit(ext_n(-wx_n), ext_n(ux_n));
		prod_d.nt_ok[EDGE_RIGHT]  = in_unit(ext_n(-wxr), ext_n(ux_n));

		prod_d.p1  = ux_w * wy_w;
		prod_d.p2  = uy_w * wx_w;
		prod_d.uxs = ux_w <<< prep_s1.sh;
		prod_d.uys = uy_w <<< prep_s1.sh;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

[hw/rtl/sqi_cross.sv]
// sqi_cross: stages three to five, segment parameter numerators per edge
// and the final range compares. depends on sqi_pkg.
module sqi_cross (
	input  logic                clk,
	input  sqi_pkg::stage_en_t  en,
	input  sqi_pkg::prod_t      prod_s2,
	output logic                hit_s5
);
	import sqi_pkg::*;

	logic                  ok_s3, enclosed_s3;
	logic [NUM_EDGES-1:0]  nt_s3;
	logic signed [PW-1:0]  k_s3, uxs_s3, uys_s3;

	logic                  ok_s4, enclosed_s4;
	logic [NUM_EDGES-1:0]  nt_s4;
	logic signed [PW-1:0]  nsb_s4, nst_s4, nsr_s4, dh_s4, dv_s4;

	logic [NUM_EDGES-1:0]  edge_hit;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ok_s3       <= prod_s2.ok;
			enclosed_s3 <= prod_s2.enclosed;
			nt_s3       <= prod_s2.nt_ok;
			k_s3        <= prod_s2.p1 - prod_s2.p2;
			uxs_s3      <= prod_s2.uxs;
			uys_s3      <= prod_s2.uys;
		end
	end

	// numerators relative to each edge start point
	always_ff @(posedge clk) begin
		if (en.s4) begin
			ok_s4       <= ok_s3;
			enclosed_s4 <= enclosed_s3;
			nt_s4       <= nt_s3;
			nsb_s4      <= k_s3;
			nst_s4      <= k_s3 - uxs_s3;
			nsr_s4      <= k_s3 + uys_s3;
			dh_s4       <= -uys_s3;
			dv_s4       <= uxs_s3;
		end
	end

	always_comb begin
		edge_hit[EDGE_BOTTOM] = nt_s4[EDGE_BOTTOM] && in_unit(nsb_s4, dh_s4);
		edge_hit[EDGE_TOP]    = nt_s4[EDGE_TOP] && in_unit(nst_s4, dh_s4);
		edge_hit[EDGE_LEFT]   = nt_s4[EDGE_LEFT] && in_unit(nsb_s4, dv_s4);
		edge_hit[EDGE_RIGHT]  = nt_s4[EDGE_RIGHT] && in_unit(nsr_s4, dv_s4);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			hit_s5 <= ok_s4 && ((|edge_hit) || enclosed_s4);
		end
	end

endmodule

[hw/rtl/segment_quadrant_intersect.sv]
// segment_quadrant_intersect: top level, valid tracking, stall control and
// the target level register. depends on sqi_pkg, sqi_prep, sqi_prod, sqi_cross.
//
// Takes one query per cycle while the output is not stalled and returns one
// hit bit per query, in order. The five register stages are: differences,
// the two 32x32 cross products, their 64-bit difference, the per-edge
// numerators, and the 64-bit range compares. A stage advances whenever it
// is empty or the stage after it advances, so empty slots are squeezed out
// under back-pressure and in_ready follows out_ready combinationally
// through that chain. Writes to target_level are always accepted and
// should be made while no query is in flight.
module segment_quadrant_intersect (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sqi_pkg::LVL_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sqi_pkg::TREE_W-1:0]  quad_tree,
	input  logic [sqi_pkg::QC_W-1:0]    quad_x,
	input  logic [sqi_pkg::QC_W-1:0]    quad_y,
	input  logic [sqi_pkg::LVL_W-1:0]   quad_level,
	input  logic [sqi_pkg::TREE_W-1:0]  seg_tree,
	input  logic [sqi_pkg::SC_W-1:0]    seg_x1,
	input  logic [sqi_pkg::SC_W-1:0]    seg_y1,
	input  logic [sqi_pkg::SC_W-1:0]    seg_x2,
	input  logic [sqi_pkg::SC_W-1:0]    seg_y2,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit
);
	import sqi_pkg::*;

	logic [LVL_W-1:0] target_level_q;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	stage_en_t        en;
	prep_t            prep_s1;
	prod_t            prod_s2;
	logic             hit_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_level_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_level_q <= cfg_data;
		end
	end

	always_comb begin
		en.s5 = !v_s5 || out_ready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s5;
	assign hit       = hit_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	sqi_prep u_prep (
		.clk          (clk),
		.en           (en),
		.target_level (target_level_q),
		.quad_tree    (quad_tree),
		.quad_x       (quad_x),
		.quad_y       (quad_y),
		.quad_level   (quad_level),
		.seg_tree     (seg_tree),
		.seg_x1       (seg_x1),
		.seg_y1       (seg_y1),
		.seg_x2       (seg_x2),
		.seg_y2       (seg_y2),
		.prep_s1      (prep_s1)
	);

	sqi_prod u_prod (
		.clk     (clk),
		.en      (en),
		.prep_s1 (prep_s1),
		.prod_s2 (prod_s2)
	);

	sqi_cross u_cross (
		.clk     (clk),
		.en      (en),
		.prod_s2 (prod_s2),
		.hit_s5  (hit_s5)
	);

	// items in flight change only by transfers
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones({v_s1, v_s2, v_s3, v_s4, v_s5}) ==
			$past($countones({v_s1, v_s2, v_s3, v_s4, v_s5}))
			+ $past(int'(in_valid && in_ready))
			- $past(int'(out_valid && out_ready))))
		else $error("pipeline occupancy mismatch");

	// an empty output stage never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s5 |-> in_ready)
		else $error("input stalled with empty output stage");

	a_tree_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (quad_tree != seg_tree)) |=> !prep_s1.ok)
		else $error("tree mismatch not gated");

	a_level_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(cfg_valid && cfg_ready)
			&& (quad_level >= target_level_q)) |=> !prep_s1.ok)
		else $error("target level not gated");

endmodule

[tb/segment_quadrant_intersect_tb.sv]
// segment_quadrant_intersect_tb: self-checking testbench for the segment / quadrant
// intersection block, with its own exact integer model of the refine flag.
// depends on sqi_pkg and segment_quadrant_intersect.
`timescale 1ns / 100ps

module segment_quadrant_intersect_tb;

	import sqi_pkg::*;

	localparam longint ROOT    = longint'(1) << MAX_LEVEL;
	localparam longint HALF    = ROOT >> 1;
	localparam longint QC_MAX  = (longint'(1) << QC_W) - 1;
	localparam longint SEG_MAX = (longint'(1) << SC_W) - 1;

	typedef struct packed {
		logic [TREE_W-1:0] quad_tree;
		logic [QC_W-1:0]   quad_x;
		logic [QC_W-1:0]   quad_y;
		logic [LVL_W-1:0]  quad_level;
		logic [TREE_W-1:0] seg_tree;
		logic [SC_W-1:0]   seg_x1;
		logic [SC_W-1:0]   seg_y1;
		logic [SC_W-1:0]   seg_x2;
		logic [SC_W-1:0]   seg_y2;
	} query_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LVL_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [TREE_W-1:0] quad_tree;
	logic [QC_W-1:0]   quad_x;
	logic [QC_W-1:0]   quad_y;
	logic [LVL_W-1:0]  quad_level;
	logic [TREE_W-1:0] seg_tree;
	logic [SC_W-1:0]   seg_x1;
	logic [SC_W-1:0]   seg_y1;
	logic [SC_W-1:0]   seg_x2;
	logic [SC_W-1:0]   seg_y2;
	logic              out_valid;
	logic              out_ready;
	logic              hit;

	logic [LVL_W-1:0]  target_lvl;
	logic              expected_hits[$];
	logic              exp_hit;
	logic              tx_steady;
	logic              rx_steady;
	int                mismatch_cnt;
	int                checked_cnt;
	int                flag_cnt;
	int                cfg_writes;

	segment_quadrant_intersect dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.quad_tree  (quad_tree),
		.quad_x     (quad_x),
		.quad_y     (quad_y),
		.quad_level (quad_level),
		.seg_tree   (seg_tree),
		.seg_x1     (seg_x1),
		.seg_y1     (seg_y1),
		.seg_x2     (seg_x2),
		.seg_y2     (seg_y2),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit)
	);

	always #6 clk = ~clk;

	// closed segment A-B against closed segment C-E, parallel counts as no crossing
	function automatic logic segments_cross(input longint ax, input longint ay,
	                                        input longint bx, input longint by,
	                                        input longint cx, input longint cy,
	                                        input longint ex, input longint ey);
		longint ux, uy, vx, vy, wx, wy, det, ns, nt;
		ux = bx - ax;
		uy = by - ay;
		vx = ex - cx;
		vy = ey - cy;
		wx = ax - cx;
		wy = ay - cy;
		det = ux * vy - vx * uy;
		ns = ux * wy - uy * wx;
		nt = vx * wy - vy * wx;
		if (det == 0)
			return 1'b0;
		if (det > 0)
			return ns >= 0 && ns <= det && nt >= 0 && nt <= det;
		return ns <= 0 && ns >= det && nt <= 0 && nt >= det;
	endfunction

	function automatic logic predict_refine(input query_t q);
		longint qx, qy, x1, y1, x2, y2, side, xr, yt;
		int     eff;
		if (q.quad_tree != q.seg_tree || q.quad_level >= target_lvl)
			return 1'b0;
		eff = (q.quad_level > MAX_LEVEL) ? MAX_LEVEL : int'(q.quad_level);
		side = longint'(1) << (MAX_LEVEL - eff);
		qx = longint'(q.quad_x);
		qy = longint'(q.quad_y);
		x1 = longint'(q.seg_x1);
		y1 = longint'(q.seg_y1);
		x2 = longint'(q.seg_x2);
		y2 = longint'(q.seg_y2);
		xr = qx + side;
		yt = qy + side;
		if (segments_cross(x1, y1, x2, y2, qx, qy, xr, qy) ||
		    segments_cross(x1, y1, x2, y2, qx, yt, xr, yt) ||
		    segments_cross(x1, y1, x2, y2, qx, qy, qx, yt) ||
		    segments_cross(x1, y1, x2, y2, xr, qy, xr, yt))
			return 1'b1;
		return x1 >= qx && x1 <= xr && y1 >= qy && y1 <= yt;
	endfunction

	function automatic query_t make_query(input int qt, input longint qx, input longint qy,
	                                      input int lvl, input int st,
	                                      input longint x1, input longint y1,
	                                      input longint x2, input longint y2);
		query_t q;
		q.quad_tree  = qt[TREE_W-1:0];
		q.quad_x     = qx[QC_W-1:0];
		q.quad_y     = qy[QC_W-1:0];
		q.quad_level = lvl[LVL_W-1:0];
		q.seg_tree   = st[TREE_W-1:0];
		q.seg_x1     = x1[SC_W-1:0];
		q.seg_y1     = y1[SC_W-1:0];
		q.seg_x2     = x2[SC_W-1:0];
		q.seg_y2     = y2[SC_W-1:0];
		return q;
	endfunction

	// coordinate around a square edge: on it, just off it, or within a side of it
	function automatic longint near_coord(input longint base, input longint side);
		longint v;
		case ($urandom_range(0, 9))
			0: v = base;
			1: v = base + side;
			2: v = base - 1;
			3: v = base + side + 1;
			default: v = base - side + longint'($urandom_range(0, int'(3 * side)));
		endcase
		if (v < 0)
			v = 0;
		if (v > SEG_MAX)
			v = SEG_MAX;
		return v;
	endfunction

	function automatic query_t random_query();
		int     qt, st, lvl, eff, mode;
		longint qx, qy, side, x1, y1, x2, y2;
		qt = $urandom_range(0, 7);
		st = ($urandom_range(0, 99) < 85) ? qt : $urandom_range(0, 7);
		if (target_lvl != 0 && $urandom_range(0, 99) < 75)
			lvl = $urandom_range(0, target_lvl - 1);
		else
			lvl = $urandom_range(0, 31);
		qx = $urandom_range(0, int'(QC_MAX));
		qy = $urandom_range(0, int'(QC_MAX));
		eff = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
		side = longint'(1) << (MAX_LEVEL - eff);
		mode = $urandom_range(0, 99);
		if (mode < 10) begin
			x1 = longint'($urandom) & SEG_MAX;
			y1 = longint'($urandom) & SEG_MAX;
			x2 = longint'($urandom) & SEG_MAX;
			y2 = longint'($urandom) & SEG_MAX;
		end else begin
			x1 = near_coord(qx, side);
			y1 = near_coord(qy, side);
			x2 = near_coord(qx, side);
			y2 = near_coord(qy, side);
			// axis-parallel segments and single points
			if (mode < 25) begin
				if ($urandom_range(0, 1))
					y2 = y1;
				else
					x2 = x1;
			end else if (mode < 30) begin
				x2 = x1;
				y2 = y1;
			end
		end
		return make_query(qt, qx, qy, lvl, st, x1, y1, x2, y2);
	endfunction

	task automatic send_query(input query_t q);
		while (!tx_steady && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		quad_tree  <= q.quad_tree;
		quad_x     <= q.quad_x;
		quad_y     <= q.quad_y;
		quad_level <= q.quad_level;
		seg_tree   <= q.seg_tree;
		seg_x1     <= q.seg_x1;
		seg_y1     <= q.seg_y1;
		seg_x2     <= q.seg_x2;
		seg_y2     <= q.seg_y2;
		do @(posedge clk); while (!in_ready);
		expected_hits.push_back(predict_refine(q));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_target(input logic [LVL_W-1:0] lvl);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= lvl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		target_lvl = lvl;
		cfg_writes++;
	endtask

	task automatic test_reset_target();
		repeat (6) send_query(random_query());
		drain_results();
	endtask

	task automatic test_directed();
		write_target(5'd30);
		send_query(make_query(0, 0, 0, 0, 1, HALF, HALF, HALF, HALF));
		send_query(make_query(2, HALF, HALF, 30, 2, HALF, HALF, HALF, HALF));
		send_query(make_query(0, 0, 0, 0, 0, 100, 200, 300, 400));
		send_query(make_query(1, HALF, HALF, 1, 1, HALF + 10, 0, HALF + 10, ROOT + 5));
		send_query(make_query(1, HALF, HALF, 1, 1, 0, 0, 10, SEG_MAX));
		send_query(make_query(3, HALF, HALF, 1, 3, HALF - 10, HALF, ROOT + 10, HALF));
		send_query(make_query(3, HALF, HALF, 1, 3, HALF - 10, HALF, HALF - 5, HALF));
		send_query(make_query(4, HALF, HALF, 1, 4, ROOT, ROOT, ROOT, ROOT));
		send_query(make_query(4, HALF, HALF, 1, 4, ROOT + 1, ROOT, ROOT + 1, ROOT));
		send_query(make_query(5, HALF, HALF, 1, 5, HALF - 100, HALF - 50, HALF, HALF));
		send_query(make_query(5, QC_MAX, QC_MAX, 0, 5, SEG_MAX, SEG_MAX, SEG_MAX, 0));
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(7, 0, 0, 0, 7, ROOT, ROOT, 0, 0));
		send_query(make_query(6, 0, 0, 0, 7, 0, 0, 0, 0));
		send_query(make_query(0, 4, 4, 29, 0, 0, 0, 100, 100));
		send_query(make_query(0, 4, 4, 29, 0, 0, 10, 3, 100));
		write_target(5'd31);
		send_query(make_query(0, 5, 5, 30, 0, 6, 6, 6, 6));
		send_query(make_query(0, 5, 5, 31, 0, 6, 6, 6, 6));
		send_query(make_query(0, 5, 5, 30, 0, 7, 6, 7, 6));
		send_query(make_query(0, 5, 5, 30, 0, 4, 7, 7, 4));
		drain_results();
	endtask

	task automatic test_random_phase(input logic [LVL_W-1:0] lvl, input int n);
		write_target(lvl);
		repeat (n) send_query(random_query());
		drain_results();
	endtask

	task automatic test_steady_stream();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		test_random_phase(5'd16, 300);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	task automatic test_pause_midstream();
		write_target(5'($urandom_range(1, 31)));
		repeat (100) send_query(random_query());
		drain_results();
		repeat (100) send_query(random_query());
		drain_results();
	endtask

	always @(posedge clk)
		out_ready <= rx_steady || ($urandom_range(0, 99) >= 12);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("result with no pending query: hit=%0b", hit);
			end else begin
				exp_hit = expected_hits.pop_front();
				checked_cnt++;
				if (hit === 1'b1)
					flag_cnt++;
				if (hit !== exp_hit) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("hit mismatch on query %0d: expected %0b, got %0b",
						         checked_cnt, exp_hit, hit);
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("segment_quadrant_intersect_tb: errors");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		quad_tree    = '0;
		quad_x       = '0;
		quad_y       = '0;
		quad_level   = '0;
		seg_tree     = '0;
		seg_x1       = '0;
		seg_y1       = '0;
		seg_x2       = '0;
		seg_y2       = '0;
		out_ready    = 1'b0;
		target_lvl   = '0;
		tx_steady    = 1'b0;
		rx_steady    = 1'b0;
		mismatch_cnt = 0;
		checked_cnt  = 0;
		flag_cnt     = 0;
		cfg_writes   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_target();
		test_directed();
		test_random_phase(5'd31, 500);
		test_random_phase(5'd30, 300);
		test_random_phase(5'($urandom_range(0, 31)), 400);
		test_random_phase(5'd1, 150);
		test_steady_stream();
		test_pause_midstream();
		test_random_phase(5'd0, 50);

		drain_results();
		repeat (10) @(posedge clk);
		$display("checked %0d queries, %0d with the refine flag set, over %0d target level writes",
		         checked_cnt, flag_cnt, cfg_writes);
		$display("traffic had idle gaps, back-pressure, a gap-free stretch and a drained pause");
		if (mismatch_cnt == 0 && expected_hits.size() == 0) begin
			$display("segment_quadrant_intersect_tb: clean");
		end else begin
			$display("segment_quadrant_intersect_tb: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/sqi_pkg.sv
hw/rtl/sqi_prep.sv
hw/rtl/sqi_prod.sv
hw/rtl/sqi_cross.sv
hw/rtl/segment_quadrant_intersect.sv
tb/segment_quadrant_intersect_tb.sv
